>>> src/ipq_pkg.sv
// Package for the instruction prefetch queue.
// Holds the request codes, the channel payload types and the store control struct.
// No dependencies.
package ipq_pkg;

  localparam int unsigned IPQ_DEPTH = 6;
  localparam int unsigned NEED_W    = 3;
  localparam int unsigned COUNT_W   = 3;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_STATUS = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [15:0]       fetched_word;
    logic [15:0]       word_address;
    logic [NEED_W-1:0] needed_bytes;
  } req_t;

  typedef struct packed {
    logic               push_accepted;
    logic [7:0]         popped_byte;
    logic [15:0]        popped_address;
    logic               fetch_missed;
    logic [COUNT_W-1:0] byte_count;
    logic               is_full;
    logic               is_empty;
    logic [7:0]         front_byte;
    logic               enough_bytes;
  } rsp_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        flush;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [15:0] lo_addr;
    logic [15:0] hi_addr;
  } store_ctrl_t;

endpackage

>>> src/ipq_req_if.sv
// Request channel of the instruction prefetch queue.
// Valid/ready handshake carrying ipq_pkg::req_t.
interface ipq_req_if;
  import ipq_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/ipq_rsp_if.sv
// Response channel of the instruction prefetch queue.
// Valid/ready handshake carrying ipq_pkg::rsp_t.
interface ipq_rsp_if;
  import ipq_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/instruction_prefetch_queue.sv
// Top level of the instruction prefetch queue.
// Depends on ipq_pkg, ipq_req_if, ipq_rsp_if and ipq_store.
//
// Usage:
//   req_i carries one request per transfer: push a 16-bit word with its
//   address (low byte first, high byte at address plus one), pop the head
//   byte, flush, or status only. needed_bytes asks whether that many bytes
//   are held.
//   rsp_o returns exactly one response per request, in order: the pop data,
//   the push outcome, the miss flag and the queue status after the request.
//   A push is refused while QueueDepth-1 or more bytes are held.
// Latency and throughput:
//   The response is valid the cycle after the request transfer. One request
//   per cycle is taken unless stalled; the queue update and the response are
//   one level of logic between the entry registers and the response register.
// Reset:
//   The queue empties, all entries and the miss flag clear, no response is
//   pending.
// Stall:
//   While a response waits and rsp_o.ready is low, req_i.ready is low; a
//   request is taken in the same cycle the waiting response transfers.
module instruction_prefetch_queue #(
  parameter int unsigned QueueDepth = ipq_pkg::IPQ_DEPTH
) (
  input logic      clk_i,
  input logic      rst_ni,
  ipq_req_if.sink  req_i,
  ipq_rsp_if.source rsp_o
);
  import ipq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned CmpW = (CntW > NEED_W) ? CntW : NEED_W;

  req_t            req;
  req_type_e       op;
  logic            in_xfer;
  logic            push_ok;
  store_ctrl_t     ctrl;
  logic [CntW-1:0] count, nxt_count;
  logic [7:0]      front_byte, nxt_front_byte;
  logic [15:0]     front_addr;
  logic            miss_q, miss_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  assign req     = req_i.payload;
  assign op      = req_type_e'(req.req_type);
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign in_xfer = req_i.valid && req_i.ready;
  assign push_ok = count < CntW'(QueueDepth - 1);

  always_comb begin
    ctrl         = '0;
    ctrl.lo_byte = req.fetched_word[7:0];
    ctrl.hi_byte = req.fetched_word[15:8];
    ctrl.lo_addr = req.word_address;
    ctrl.hi_addr = req.word_address + 16'd1;
    miss_d       = miss_q;
    unique case (op)
      REQ_PUSH: begin
        ctrl.push = in_xfer && push_ok;
      end
      REQ_POP: begin
        if (in_xfer) begin
          if (count == '0) begin
            miss_d = 1'b1;
          end else begin
            ctrl.pop = 1'b1;
            miss_d   = 1'b0;
          end
        end
      end
      REQ_FLUSH: begin
        ctrl.flush = in_xfer;
        if (in_xfer) begin
          miss_d = 1'b0;
        end
      end
      REQ_STATUS: begin
      end
    endcase
  end

  ipq_store #(
    .Depth(QueueDepth)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .count_o         (count),
    .nxt_count_o     (nxt_count),
    .front_byte_o    (front_byte),
    .front_addr_o    (front_addr),
    .nxt_front_byte_o(nxt_front_byte)
  );

  always_comb begin
    rsp_d.push_accepted  = ctrl.push;
    rsp_d.popped_byte    = ctrl.pop ? front_byte : 8'h00;
    rsp_d.popped_address = ctrl.pop ? front_addr : 16'h0000;
    rsp_d.fetch_missed   = miss_d;
    rsp_d.byte_count     = COUNT_W'(nxt_count);
    rsp_d.is_full        = nxt_count >= CntW'(QueueDepth - 1);
    rsp_d.is_empty       = nxt_count == '0;
    rsp_d.front_byte     = (nxt_count == '0) ? 8'h00 : nxt_front_byte;
    rsp_d.enough_bytes   = CmpW'(req.needed_bytes) <= CmpW'(nxt_count);
  end

  // hold the response until it transfers; load a new one on every request
  always_comb begin
    if (in_xfer) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      miss_q      <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      miss_q      <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(QueueDepth))
    else $error("queue count above depth");

  a_refused_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op == REQ_PUSH && !push_ok) |=> $stable(count))
    else $error("refused push changed the count");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op == REQ_FLUSH) |=> (count == '0 && !miss_q))
    else $error("flush left bytes or miss flag");

  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.push_accepted) |-> !rsp_q.is_empty)
    else $error("accepted push reported empty queue");

  a_no_xfer_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !in_xfer)
    else $error("request taken over a stalled response");

endmodule

>>> src/ipq_store.sv
// Byte/address storage of the prefetch queue: a shift line with the head at entry 0.
// Entries at and beyond the count are kept at zero. Depends on ipq_pkg.
module ipq_store #(
  parameter int unsigned Depth = ipq_pkg::IPQ_DEPTH,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipq_pkg::store_ctrl_t ctrl_i,
  output logic [CntW-1:0]      count_o,
  output logic [CntW-1:0]      nxt_count_o,
  output logic [7:0]           front_byte_o,
  output logic [15:0]          front_addr_o,
  output logic [7:0]           nxt_front_byte_o
);
  import ipq_pkg::*;

  logic [7:0]      byte_q [Depth];
  logic [7:0]      byte_d [Depth];
  logic [15:0]     addr_q [Depth];
  logic [15:0]     addr_d [Depth];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_p1;

  assign count_p1 = count_q + CntW'(1);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      byte_d[i] = byte_q[i];
      addr_d[i] = addr_q[i];
      if (ctrl_i.flush) begin
        byte_d[i] = '0;
        addr_d[i] = '0;
      end else if (ctrl_i.pop) begin
        // advance toward the head; the tail slot takes zero
        if (i < Depth - 1) begin
          byte_d[i] = byte_q[i+1];
          addr_d[i] = addr_q[i+1];
        end else begin
          byte_d[i] = '0;
          addr_d[i] = '0;
        end
      end else if (ctrl_i.push) begin
        if (CntW'(i) == count_q) begin
          byte_d[i] = ctrl_i.lo_byte;
          addr_d[i] = ctrl_i.lo_addr;
        end
        if (CntW'(i) == count_p1) begin
          byte_d[i] = ctrl_i.hi_byte;
          addr_d[i] = ctrl_i.hi_addr;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.flush) begin
      count_d = '0;
    end else if (ctrl_i.pop) begin
      count_d = count_q - CntW'(1);
    end else if (ctrl_i.push) begin
      count_d = count_q + CntW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < Depth; i++) begin
        byte_q[i] <= '0;
        addr_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      for (int i = 0; i < Depth; i++) begin
        byte_q[i] <= byte_d[i];
        addr_q[i] <= addr_d[i];
      end
    end
  end

  assign count_o          = count_q;
  assign nxt_count_o      = count_d;
  assign front_byte_o     = byte_q[0];
  assign front_addr_o     = addr_q[0];
  assign nxt_front_byte_o = byte_d[0];

endmodule

>>> dv/instruction_prefetch_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for the instruction prefetch queue.
// It predicts every response and checks each one field by field.
// Depends on ipq_pkg, ipq_req_if, ipq_rsp_if and instruction_prefetch_queue.
module instruction_prefetch_queue_tb;
  import ipq_pkg::*;

  logic clk;
  logic rst_n;

  ipq_req_if req_if ();
  ipq_rsp_if rsp_if ();

  instruction_prefetch_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Prediction state
  logic [7:0]  q_bytes[IPQ_DEPTH];
  logic [15:0] q_addrs[IPQ_DEPTH];
  int unsigned q_count;
  logic        q_miss;

  rsp_t pending_status[$];
  int   mismatch_count = 0;

  int   tx_idle_pct = 12;
  int   rx_idle_pct = 12;
  bit   long_stall_pending = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("instruction_prefetch_queue_tb: errors");
    $finish;
  end

  function automatic void clear_queue_model();
    int i;
    for (i = 0; i < IPQ_DEPTH; i++) begin
      q_bytes[i] = '0;
      q_addrs[i] = '0;
    end
    q_count = 0;
    q_miss  = 1'b0;
  endfunction

  // Apply one request to the prediction state and return the status it yields.
  function automatic rsp_t queue_step(input req_t r);
    rsp_t e;
    int   i;
    e = '0;
    case (req_type_e'(r.req_type))
      REQ_PUSH: begin
        if (q_count + 1 < IPQ_DEPTH) begin
          q_bytes[q_count]     = r.fetched_word[7:0];
          q_addrs[q_count]     = r.word_address;
          q_bytes[q_count + 1] = r.fetched_word[15:8];
          q_addrs[q_count + 1] = r.word_address + 16'd1;
          q_count += 2;
          e.push_accepted = 1'b1;
        end
      end
      REQ_POP: begin
        if (q_count == 0) begin
          q_miss = 1'b1;
        end else begin
          e.popped_byte    = q_bytes[0];
          e.popped_address = q_addrs[0];
          q_miss = 1'b0;
          q_count -= 1;
          for (i = 0; i < q_count; i++) begin
            q_bytes[i] = q_bytes[i + 1];
            q_addrs[i] = q_addrs[i + 1];
          end
          q_bytes[q_count] = '0;
          q_addrs[q_count] = '0;
        end
      end
      REQ_FLUSH: clear_queue_model();
      default: ;
    endcase
    e.fetch_missed = q_miss;
    e.byte_count   = COUNT_W'(q_count);
    e.is_full      = (q_count + 1 >= IPQ_DEPTH);
    e.is_empty     = (q_count == 0);
    e.front_byte   = (q_count == 0) ? 8'h00 : q_bytes[0];
    e.enough_bytes = (r.needed_bytes <= q_count);
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 200) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp);
    if (got !== exp) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, exp));
    end
  endtask

  task automatic check_status(input rsp_t got, input rsp_t exp);
    check_field("push_accepted", 16'(got.push_accepted), 16'(exp.push_accepted));
    check_field("popped_byte", 16'(got.popped_byte), 16'(exp.popped_byte));
    check_field("popped_address", got.popped_address, exp.popped_address);
    check_field("fetch_missed", 16'(got.fetch_missed), 16'(exp.fetch_missed));
    check_field("byte_count", 16'(got.byte_count), 16'(exp.byte_count));
    check_field("is_full", 16'(got.is_full), 16'(exp.is_full));
    check_field("is_empty", 16'(got.is_empty), 16'(exp.is_empty));
    check_field("front_byte", 16'(got.front_byte), 16'(exp.front_byte));
    check_field("enough_bytes", 16'(got.enough_bytes), 16'(exp.enough_bytes));
  endtask

  // Check the outgoing transfer first, then record the incoming one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          check_status(rsp_if.payload, pending_status.pop_front());
        end
      end
      if (req_if.valid && req_if.ready) begin
        pending_status.push_back(queue_step(req_if.payload));
      end
    end
  end

  // Response sink: random stalls, plus one long hold when requested.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_pending) begin
        long_stall_pending = 1'b0;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(input req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_op(input req_type_e op, input logic [15:0] word,
                         input logic [15:0] addr, input logic [2:0] need);
    req_t r;
    r.req_type     = op;
    r.fetched_word = word;
    r.word_address = addr;
    r.needed_bytes = need;
    send_request(r);
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 36)      r.req_type = REQ_PUSH;
    else if (pick < 72) r.req_type = REQ_POP;
    else if (pick < 80) r.req_type = REQ_FLUSH;
    else                r.req_type = REQ_STATUS;
    r.fetched_word = 16'($urandom);
    // Lean on the top of the address space so the wrap shows up often.
    r.word_address = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(1))
                                              : 16'($urandom);
    r.needed_bytes = 3'($urandom_range(7));
    return r;
  endfunction

  task automatic test_directed_corners();
    send_op(REQ_POP,    16'h0000, 16'h0000, 3'd0);  // pop on empty sets the miss flag
    send_op(REQ_STATUS, 16'hFFFF, 16'hFFFF, 3'd7);  // status keeps the miss flag
    send_op(REQ_PUSH,   16'h0000, 16'h0000, 3'd2);  // push keeps the miss flag
    send_op(REQ_POP,    16'hFFFF, 16'hFFFF, 3'd1);
    send_op(REQ_PUSH,   16'hFFFF, 16'hFFFF, 3'd3);  // high byte address wraps
    send_op(REQ_PUSH,   16'hA55A, 16'h1234, 3'd5);
    send_op(REQ_PUSH,   16'h1111, 16'h2000, 3'd5);  // refused at five held
    send_op(REQ_STATUS, 16'h0000, 16'h0000, 3'd6);
    send_op(REQ_POP,    16'h0000, 16'h0000, 3'd4);
    send_op(REQ_PUSH,   16'hBEEF, 16'hFFFE, 3'd6);  // fills all six entries
    send_op(REQ_PUSH,   16'h7E81, 16'h8000, 3'd6);  // refused when full
    send_op(REQ_STATUS, 16'h0000, 16'h0000, 3'd6);
    send_op(REQ_STATUS, 16'h0000, 16'h0000, 3'd7);
    repeat (6) send_op(REQ_POP, 16'h0000, 16'h0000, 3'd0);
    send_op(REQ_POP,    16'h0000, 16'h0000, 3'd0);
    send_op(REQ_FLUSH,  16'h0000, 16'h0000, 3'd0);  // flush clears the miss flag
    send_op(REQ_PUSH,   16'h00FF, 16'h7FFF, 3'd1);
    send_op(REQ_FLUSH,  16'hFFFF, 16'hFFFF, 3'd7);  // flush with bytes held
    send_op(REQ_STATUS, 16'h0000, 16'h0000, 3'd0);
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) send_request(random_request());
  endtask

  // Hold the sink while requests keep coming, so the input stalls.
  task automatic test_back_pressure();
    tx_idle_pct = 0;
    long_stall_pending = 1'b1;
    repeat (100) send_request(random_request());
    tx_idle_pct = 12;
  endtask

  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (200) send_request(random_request());
    tx_idle_pct = 12;
    rx_idle_pct = 12;
  endtask

  initial begin
    clear_queue_model();
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_traffic(300);
    test_back_pressure();
    test_back_to_back();
    test_random_traffic(250);

    req_if.valid <= 1'b0;
    // let the last transfer reach the checker before draining
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_status.size() != 0) begin
      report_mismatch("requests left without a response");
    end
    if (mismatch_count == 0) begin
      $display("instruction_prefetch_queue_tb: clean");
    end else begin
      $display("instruction_prefetch_queue_tb: errors");
    end
    $finish;
  end

endmodule
